/* sv/piecewise_linear_interpolator_core_assert.svh */
// Assertion macros for the piecewise linear interpolator checker.
// No dependencies; taken in by the checker file only.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// Check a condition at every edge outside reset.
`define PWLI_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define PWLI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define PWLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pwli_pkg.sv */
// Shared types and constants of the piecewise linear interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pwli_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int PT_IDX_W    = $clog2(MAX_POINTS);
   localparam int LEN_W       = 5;
   localparam int ENTRY_IDX_W = 4;
   localparam int DATA_W      = 32;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_COEFF = CSR_IDX_W'(1);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Quotient is below 2^32 + 1, so 33 quotient bits are enough.
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SINGLE,
      CMD_TABLE
   } cmd_kind_type;

   // index: entry address for a write, last used breakpoint for a query.
   // temp:  breakpoint temperature for a write, query temperature otherwise.
   // value: breakpoint value for a write, single coefficient otherwise.
   typedef struct packed {
      cmd_kind_type               kind;
      logic [PT_IDX_W-1:0]        index;
      logic                       entry_ok;
      logic signed [DATA_W-1:0]   temp;
      logic signed [DATA_W-1:0]   value;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST,
      ST_FIRST,
      ST_SCAN,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

/* sv/pwli_front.sv */
// Front end: configuration registers and classification of incoming items.
// Depends on pwli_pkg; feeds pwli_queue.
`default_nettype none

module pwli_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic                                  req_mode,
   input  logic [pwli_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_entry_temperature,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_entry_value,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_query_temperature,
   input  logic                                  csr_we,
   input  logic [pwli_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pwli_pkg::DATA_W-1:0]           csr_wdata,
   input  logic                                  queue_full,
   output logic                                  queue_push,
   output pwli_pkg::cmd_type                     queue_din
);
   import pwli_pkg::*;

   logic [LEN_W-1:0]         length_ff, length_in;
   logic signed [DATA_W-1:0] single_ff, single_in;
   logic [PT_IDX_W-1:0]      last_index;
   logic                     use_single;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         single_ff <= '0;
      end else begin
         length_ff <= length_in;
         single_ff <= single_in;
      end
   end

   always_comb begin
      length_in = length_ff;
      single_in = single_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_LENGTH: length_in = csr_wdata[LEN_W-1:0];
            CSR_SINGLE_COEFF: single_in = csr_wdata;
         endcase
      end
   end

   // Treat length zero as one, and clip the length to the table depth.
   always_comb begin
      use_single = (length_ff <= LEN_W'(1));
      if (32'(length_ff) >= MAX_POINTS) begin
         last_index = PT_IDX_W'(MAX_POINTS - 1);
      end else begin
         last_index = PT_IDX_W'(length_ff - LEN_W'(1));
      end
   end

   always_comb begin
      queue_push = req_push && !queue_full;
      if (req_mode == MODE_WRITE) begin
         queue_din.kind     = CMD_WRITE;
         queue_din.index    = PT_IDX_W'(req_entry_index);
         queue_din.entry_ok = (32'(req_entry_index) < MAX_POINTS);
         queue_din.temp     = req_entry_temperature;
         queue_din.value    = req_entry_value;
      end else begin
         queue_din.kind     = use_single ? CMD_SINGLE : CMD_TABLE;
         queue_din.index    = last_index;
         queue_din.entry_ok = 1'b1;
         queue_din.temp     = req_query_temperature;
         queue_din.value    = single_ff;
      end
   end

endmodule

`default_nettype wire

/* sv/pwli_queue.sv */
// Short command queue between the front end and the back end.
// Depends on pwli_pkg for the command type and depth.
`default_nettype none

module pwli_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pwli_pkg::cmd_type din,
   output logic              full,
   input  logic              pop,
   output pwli_pkg::cmd_type dout,
   output logic              empty
);
   import pwli_pkg::*;

   cmd_type                slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   push_ok, pop_ok;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

/* sv/pwli_back.sv */
// Back end: breakpoint memories, search sequencer, serial divider, result register.
// Depends on pwli_pkg; drains pwli_queue.
`default_nettype none

module pwli_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               queue_empty,
   input  pwli_pkg::cmd_type                  queue_dout,
   output logic                               queue_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic signed [pwli_pkg::DATA_W-1:0] rsp_result_value
);
   import pwli_pkg::*;

   logic signed [DATA_W-1:0] temp_mem  [MAX_POINTS];
   logic signed [DATA_W-1:0] value_mem [MAX_POINTS];

   back_state_type           state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   logic signed [DATA_W-1:0] rd_temp_ff, rd_value_ff;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic [PT_IDX_W-1:0]      last_ff, last_in;
   logic [PT_IDX_W-1:0]      idx_ff, idx_in;
   logic signed [DATA_W-1:0] tlo_ff, tlo_in, thi_ff, thi_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [DATA_W-1:0]        dx_ff, dx_in, dt_ff, dt_in;
   logic [DATA_W:0]          mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [2*DATA_W-1:0]      num_ff, num_in;
   logic [DIV_STEPS-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] res_ff, res_in;

   logic [PT_IDX_W-1:0]      rd_addr;
   logic                     mem_we;
   logic                     slot_free;
   logic signed [DATA_W:0]   dy;
   logic [2*DATA_W-1:0]      prod;
   logic [DATA_W:0]          trial;
   logic [DATA_W:0]          dt_ext;
   logic                     trial_ge;
   logic [DATA_W+1:0]        lo_ext, quo_ext, sum;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   assign dy       = {hi_ff[DATA_W-1], hi_ff} - {lo_ff[DATA_W-1], lo_ff};
   assign prod     = (2*DATA_W)'(dx_ff) * (2*DATA_W)'(mag_ff);
   assign trial    = {rem_ff, num_ff[2*DATA_W-1]};
   assign dt_ext   = {1'b0, dt_ff};
   assign trial_ge = (trial >= dt_ext);
   assign lo_ext   = {{2{lo_ff[DATA_W-1]}}, lo_ff};
   assign quo_ext  = (DATA_W+2)'(quo_ff);
   assign sum      = neg_ff ? lo_ext - quo_ext : lo_ext + quo_ext;

   // Table memories: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         temp_mem[queue_dout.index]  <= queue_dout.temp;
         value_mem[queue_dout.index] <= queue_dout.value;
      end
      rd_temp_ff  <= temp_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      x_ff         <= x_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      tlo_ff       <= tlo_in;
      thi_ff       <= thi_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      dx_ff        <= dx_in;
      dt_ff        <= dt_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_value_in = rsp_value_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      dx_in        = dx_ff;
      dt_in        = dt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rd_addr      = idx_ff;
      mem_we       = 1'b0;
      queue_pop    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               unique case (queue_dout.kind)
                  CMD_WRITE: begin
                     queue_pop = 1'b1;
                     mem_we    = queue_dout.entry_ok;
                  end
                  CMD_SINGLE: begin
                     if (slot_free) begin
                        queue_pop    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_value_in = queue_dout.value;
                     end
                  end
                  CMD_TABLE: begin
                     queue_pop = 1'b1;
                     x_in      = queue_dout.temp;
                     last_in   = queue_dout.index;
                     rd_addr   = queue_dout.index;
                     state_in  = ST_LAST;
                  end
                  default: queue_pop = 1'b1;
               endcase
            end
         end
         // Upper clamp first: it wins when both ends apply.
         ST_LAST: begin
            if (x_ff >= rd_temp_ff) begin
               res_in   = rd_value_ff;
               state_in = ST_OUT;
            end else begin
               rd_addr  = '0;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (x_ff <= rd_temp_ff) begin
               res_in   = rd_value_ff;
               state_in = ST_OUT;
            end else begin
               tlo_in   = rd_temp_ff;
               lo_in    = rd_value_ff;
               idx_in   = PT_IDX_W'(1);
               rd_addr  = PT_IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         // Walk up until a breakpoint lies above x, or the last one is reached.
         ST_SCAN: begin
            if ((x_ff < rd_temp_ff) || (idx_ff == last_ff)) begin
               thi_in   = rd_temp_ff;
               hi_in    = rd_value_ff;
               state_in = ST_PREP;
            end else begin
               tlo_in   = rd_temp_ff;
               lo_in    = rd_value_ff;
               idx_in   = idx_ff + 1'b1;
               rd_addr  = idx_ff + 1'b1;
            end
         end
         ST_PREP: begin
            dx_in    = DATA_W'(x_ff - tlo_ff);
            dt_in    = DATA_W'(thi_ff - tlo_ff);
            neg_in   = dy[DATA_W];
            mag_in   = dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
            state_in = ST_MUL;
         end
         // Load the divider; the top bits of the product are already below dt.
         ST_MUL: begin
            rem_in   = DATA_W'(prod[2*DATA_W-1:DIV_STEPS]);
            num_in   = {prod[DIV_STEPS-1:0], (2*DATA_W-DIV_STEPS)'(0)};
            quo_in   = '0;
            cnt_in   = DIV_CNT_W'(DIV_STEPS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = DATA_W'(trial - dt_ext);
            end else begin
               rem_in = trial[DATA_W-1:0];
            end
            quo_in = {quo_ff[DIV_STEPS-2:0], trial_ge};
            num_in = {num_ff[2*DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               state_in = ST_SUM;
            end
         end
         // Saturate to the signed 32-bit range.
         ST_SUM: begin
            if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
               res_in = sum[DATA_W-1:0];
            end else if (sum[DATA_W+1]) begin
               res_in = {1'b1, (DATA_W-1)'(0)};
            end else begin
               res_in = {1'b0, {(DATA_W-1){1'b1}}};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* sv/piecewise_linear_interpolator_core.sv */
// Top level of the piecewise linear interpolator: front end, command queue, back end.
// Depends on pwli_pkg, pwli_front, pwli_queue and pwli_back.
`default_nettype none

// Piecewise linear interpolation table in signed Q16.16. A write transaction
// (mode 0) stores one breakpoint temperature and its coefficient; a query
// transaction (mode 1) returns one result: the single coefficient when the
// table length is one (zero counts as one), the last value at or above the
// last breakpoint, the first value at or below the first, and otherwise
// lo + trunc((x - tlo) * (hi - lo) / (thi - tlo)) saturated to 32 bits.
// Both channels behave as queues: push while full is low, pop while empty is
// low. Accepted items wait in a two-entry command queue, so the input keeps
// taking items while the back end works or a result waits to be popped; one
// result register holds the finished answer. Items are carried out one at a
// time: a write, and a single-coefficient query once the result register is
// free, are handled in the idle state; a query clamped at the upper end reads
// the last breakpoint, one clamped at the lower end also the first, and an
// interpolated query searches the table, then prepares the deltas,
// multiplies, runs the 33-step restoring divider and saturates the sum. The
// table memory gives one entry per cycle to the search.
// Table entries read before they are written hold no defined value. Write the
// CSRs (index 0: table length, index 1: single coefficient) only while no
// transaction is in flight.
module piecewise_linear_interpolator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_mode,
   input  logic [pwli_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_entry_temperature,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_entry_value,
   input  logic signed [pwli_pkg::DATA_W-1:0]    req_query_temperature,
   // result channel
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [pwli_pkg::DATA_W-1:0]    rsp_result_value,
   // configuration port
   input  logic                                  csr_we,
   input  logic [pwli_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pwli_pkg::DATA_W-1:0]           csr_wdata
);
   import pwli_pkg::*;

   logic    queue_push, queue_pop, queue_empty;
   cmd_type queue_din, queue_dout;

   // Hold the CSRs and turn each accepted transaction into a command.
   pwli_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_mode              (req_mode),
      .req_entry_index       (req_entry_index),
      .req_entry_temperature (req_entry_temperature),
      .req_entry_value       (req_entry_value),
      .req_query_temperature (req_query_temperature),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .queue_full            (req_full),
      .queue_push            (queue_push),
      .queue_din             (queue_din)
   );

   // Decouple acceptance from execution.
   pwli_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (queue_push),
      .din   (queue_din),
      .full  (req_full),
      .pop   (queue_pop),
      .dout  (queue_dout),
      .empty (queue_empty)
   );

   // Store breakpoints, search, interpolate and present the result.
   pwli_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_dout       (queue_dout),
      .queue_pop        (queue_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_value (rsp_result_value)
   );

endmodule

`default_nettype wire

/* sv/pwli_checker.sv */
// Port-level checker for the piecewise linear interpolator, bound to the top level.
// Depends on pwli_pkg and piecewise_linear_interpolator_core_assert.svh.
`default_nettype none
`include "piecewise_linear_interpolator_core_assert.svh"

module pwli_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_push,
   input logic                                  req_full,
   input logic                                  req_mode,
   input logic                                  rsp_empty,
   input logic                                  rsp_pop,
   input logic signed [pwli_pkg::DATA_W-1:0]    rsp_result_value
);
   import pwli_pkg::*;

   // Count queries accepted but not yet popped.
   logic [2:0] pending_ff, pending_in;
   logic       query_acc, result_acc;

   assign query_acc  = req_push && !req_full && (req_mode == MODE_QUERY);
   assign result_acc = rsp_pop && !rsp_empty;

   always_comb begin
      pending_in = pending_ff;
      if (query_acc && !result_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (result_acc && !query_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `PWLI_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full, "reset left a result or a full queue")
   `PWLI_ASSERT_IMPLY(a_no_spurious, clock, reset, !rsp_empty, pending_ff != 3'd0, "result shown with no query outstanding")
   `PWLI_ASSERT_ALWAYS(a_bounded, clock, reset, 32'(pending_ff) <= CMD_DEPTH + 2, "more queries outstanding than the block can hold")
   `PWLI_ASSERT_NEXT(a_result_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_result_value), "waiting result changed or vanished")

endmodule

bind piecewise_linear_interpolator_core pwli_checker u_checker (.*);

`default_nettype wire

/* tb/tb_piecewise_linear_interpolator_core.sv */
// Self-checking testbench for piecewise_linear_interpolator_core: table writes and
// queries against a built-in interpolation predictor, with random idling on both sides.
// Depends on pwli_pkg and piecewise_linear_interpolator_core.
`default_nettype none

module tb_piecewise_linear_interpolator_core;

   import pwli_pkg::*;

   localparam int     CLOCK_PERIOD  = 12;
   localparam int     RESET_CYCLES  = 6;
   localparam int     SETTLE_CYCLES = 100;      // longest query is well under this
   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     PHASE_COUNT   = 8;
   localparam int     PHASE_ITEMS   = 115;
   localparam longint Q_MAX         = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_MIN         = -Q_MAX - 1;
   localparam longint Q_SPAN        = 64'sd4294967296;
   localparam longint NARROW_SPAN   = 64'sd1048576;
   localparam longint NARROW_STEP   = 64'sd262144;

   // One input transaction as the driver presents it.
   typedef struct {
      logic                      mode;
      logic [ENTRY_IDX_W-1:0]    index;
      logic signed [DATA_W-1:0]  entry_temp;
      logic signed [DATA_W-1:0]  entry_value;
      logic signed [DATA_W-1:0]  query_temp;
   } table_request_type;

   logic                      clock                 = 1'b0;
   logic                      reset                 = 1'b1;
   logic                      req_push              = 1'b0;
   logic                      req_full;
   logic                      req_mode              = MODE_WRITE;
   logic [ENTRY_IDX_W-1:0]    req_entry_index       = '0;
   logic signed [DATA_W-1:0]  req_entry_temperature = '0;
   logic signed [DATA_W-1:0]  req_entry_value       = '0;
   logic signed [DATA_W-1:0]  req_query_temperature = '0;
   logic                      rsp_empty;
   logic                      rsp_pop               = 1'b0;
   logic signed [DATA_W-1:0]  rsp_result_value;
   logic                      csr_we                = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index             = '0;
   logic [DATA_W-1:0]         csr_wdata             = '0;

   // Stimulus and scoreboard storage.
   table_request_type         pending_requests[$];
   logic signed [DATA_W-1:0]  expected_coefficients[$];
   int                        sender_idle_pct       = 0;
   int                        receiver_stall_pct    = 0;
   int                        mismatch_count        = 0;
   int                        cycle_count           = 0;
   int                        phase_items           = 0;

   // Predictor copy of the block's registers and table.
   logic [LEN_W-1:0]          cfg_table_length      = LEN_W'(1);
   logic signed [DATA_W-1:0]  cfg_single_coeff      = '0;
   logic signed [DATA_W-1:0]  bp_temp  [MAX_POINTS];
   logic signed [DATA_W-1:0]  bp_value [MAX_POINTS];

   // Stimulus generator's view of the table, used to aim queries at segments.
   longint                    gen_t [MAX_POINTS];

   piecewise_linear_interpolator_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_mode              (req_mode),
      .req_entry_index       (req_entry_index),
      .req_entry_temperature (req_entry_temperature),
      .req_entry_value       (req_entry_value),
      .req_query_temperature (req_query_temperature),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_result_value      (rsp_result_value),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Coefficient at temperature x for the current table and registers. The
   // length saturates to 1..MAX_POINTS; the last-value clamp is tried first so
   // that it wins when both ends apply. Between breakpoints take the first one
   // above x and its predecessor; the product of the deltas is exact in 64 bits
   // and the quotient truncates toward zero.
   function automatic logic signed [DATA_W-1:0] predict_coefficient(
      logic signed [DATA_W-1:0] x);
      int        n;
      int        i;
      longint    tlo, thi, lo, hi, dy, r;
      bit [63:0] dx, dt, mag, q;
      n = int'(cfg_table_length);
      if (n == 0) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (n == 1) return cfg_single_coeff;
      if (x >= bp_temp[n-1]) return bp_value[n-1];
      if (x <= bp_temp[0]) return bp_value[0];
      i = 1;
      while (i < n - 1 && x >= bp_temp[i]) i++;
      tlo = bp_temp[i-1];
      thi = bp_temp[i];
      lo  = bp_value[i-1];
      hi  = bp_value[i];
      dx  = 64'(longint'(x) - tlo);
      dt  = 64'(thi - tlo);
      if (dt == 0) return lo[DATA_W-1:0];
      dy  = hi - lo;
      mag = (dy < 0) ? 64'(-dy) : 64'(dy);
      q   = (dx * mag) / dt;
      r   = (dy < 0) ? lo - longint'(q) : lo + longint'(q);
      if (r > Q_MAX) r = Q_MAX;
      if (r < Q_MIN) r = Q_MIN;
      return r[DATA_W-1:0];
   endfunction

   // Uniform value in [a, b]; a must not exceed b.
   function automatic longint rand_between(longint a, longint b);
      bit [63:0] r;
      r = {$urandom(), $urandom()};
      return a + longint'(r % 64'(b - a + 1));
   endfunction

   function automatic longint rand_coefficient();
      int style;
      style = $urandom_range(2);
      if (style == 0) return longint'(int'($urandom()));
      if (style == 1) return rand_between(-NARROW_SPAN, NARROW_SPAN);
      return ($urandom_range(1) == 1) ? Q_MAX : Q_MIN;
   endfunction

   // Aim a query at the table of n breakpoints: mostly inside a segment, some
   // exactly on a breakpoint, the rest in either clamp region.
   function automatic longint pick_query_temperature(int n);
      int     k;
      int     style;
      longint a, b;
      if (n < 2) return rand_between(Q_MIN, Q_MAX);
      style = $urandom_range(99);
      if (style < 60) begin
         k = $urandom_range(n - 2);
         a = gen_t[k];
         b = gen_t[k+1];
      end else if (style < 75) begin
         k = $urandom_range(n - 1);
         return gen_t[k];
      end else if (style < 88) begin
         a = Q_MIN;
         b = gen_t[0];
      end else begin
         a = gen_t[n-1];
         b = Q_MAX;
      end
      if (a > b) return rand_between(b, a);
      return rand_between(a, b);
   endfunction

   // Queue a table write; the unused query field is randomised so it toggles.
   task automatic queue_write(int idx, longint t, longint v);
      table_request_type item;
      item.mode        = MODE_WRITE;
      item.index       = ENTRY_IDX_W'(idx);
      item.entry_temp  = t[DATA_W-1:0];
      item.entry_value = v[DATA_W-1:0];
      item.query_temp  = $urandom();
      pending_requests.push_back(item);
      gen_t[idx] = t;
      phase_items++;
   endtask

   // Queue a query; the unused entry fields are randomised so they toggle.
   task automatic queue_query(longint x);
      table_request_type item;
      item.mode        = MODE_QUERY;
      item.index       = ENTRY_IDX_W'($urandom_range(MAX_POINTS - 1));
      item.entry_temp  = $urandom();
      item.entry_value = $urandom();
      item.query_temp  = x[DATA_W-1:0];
      pending_requests.push_back(item);
      phase_items++;
   endtask

   // Rewrite entries 0..m-1 as a non-decreasing table: either spread over the
   // whole Q16.16 range or clustered with small steps and the odd repeat.
   task automatic rewrite_table(int m);
      int     k;
      int     spread;
      longint step, t;
      spread = $urandom_range(1);
      step   = Q_SPAN / m;
      t      = rand_between(-NARROW_SPAN, NARROW_SPAN);
      for (k = 0; k < m; k++) begin
         if (spread == 1) begin
            t = Q_MIN + k * step + rand_between(0, step - 1);
         end else if (k > 0) begin
            t = t + (($urandom_range(7) == 0) ? 0 : rand_between(1, NARROW_STEP));
         end
         queue_write(k, t, rand_coefficient());
      end
   endtask

   // Move one breakpoint between its neighbours so the order is kept.
   task automatic rewrite_entry(int n);
      int     k;
      longint a, b;
      k = (n < 2) ? $urandom_range(MAX_POINTS - 1) : $urandom_range(n - 1);
      a = (n < 2 || k == 0) ? Q_MIN : gen_t[k-1];
      b = (n < 2 || k >= n - 1) ? Q_MAX : gen_t[k+1];
      if (a > b) queue_write(k, rand_between(b, a), rand_coefficient());
      else queue_write(k, rand_between(a, b), rand_coefficient());
   endtask

   // Hold until every queued transaction is accepted and every result popped,
   // then let trailing writes drain out of the command queue.
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || expected_coefficients.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write at a falling edge, only ever called with the block idle.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_TABLE_LENGTH) cfg_table_length = data[LEN_W-1:0];
      else cfg_single_coeff = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: present the oldest pending transaction at the falling edge unless
   // the sender idles this cycle; randomise the result pop the same way. Push
   // gets exactly one assignment per edge, so a held push never glitches.
   always @(negedge clock) begin : drive_requests
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_push              <= 1'b1;
            req_mode              <= pending_requests[0].mode;
            req_entry_index       <= pending_requests[0].index;
            req_entry_temperature <= pending_requests[0].entry_temp;
            req_entry_value       <= pending_requests[0].entry_value;
            req_query_temperature <= pending_requests[0].query_temp;
         end else begin
            req_push <= 1'b0;
         end
         rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: at the rising edge check a popped result against the oldest
   // expectation, then run accepted transactions through the predictor in
   // order. Drop the accepted transaction from the pending queue here so the
   // driver moves on at the next falling edge.
   always @(posedge clock) begin : check_results
      logic signed [DATA_W-1:0] want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_coefficients.size() == 0) begin
               $display("%0t: result with no query waiting, expected none, got 0x%08h",
                        $time, rsp_result_value);
               mismatch_count++;
            end else begin
               want = expected_coefficients.pop_front();
               if (rsp_result_value !== want) begin
                  $display("%0t: result_value mismatch, expected 0x%08h, got 0x%08h",
                           $time, want, rsp_result_value);
                  mismatch_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_mode == MODE_WRITE) begin
               if (int'(req_entry_index) < MAX_POINTS) begin
                  bp_temp[req_entry_index]  = req_entry_temperature;
                  bp_value[req_entry_index] = req_entry_value;
               end
            end else begin
               expected_coefficients.push_back(predict_coefficient(req_query_temperature));
            end
            void'(pending_requests.pop_front());
         end
      end
   end

   initial begin : run_stimulus
      int phase_length [PHASE_COUNT];
      int p;
      int len;
      int n_eff;
      int pick;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, no idling. Query straight after reset: length one gives
      // the single coefficient, which resets to zero.
      queue_query(Q_MAX);
      // Fill the whole table before any longer length is set, so no query
      // can ever read an entry that was never written. Ends hold the extremes.
      for (p = 0; p < MAX_POINTS; p++) begin
         if (p == 0) queue_write(p, Q_MIN, Q_MAX);
         else if (p == MAX_POINTS - 1) queue_write(p, Q_MAX, Q_MIN);
         else queue_write(p, Q_MIN + p * 64'sd268435456,
                          (p % 2 == 1) ? Q_MIN + p : Q_MAX - p);
      end
      wait_until_drained();
      write_register(CSR_TABLE_LENGTH, DATA_W'(MAX_POINTS));
      write_register(CSR_SINGLE_COEFF, 32'h7FFF_FFFF);
      queue_query(Q_MIN);               // on the first breakpoint
      queue_query(Q_MAX);               // on the last breakpoint
      queue_query(gen_t[5]);            // exactly on an inner breakpoint
      queue_query(Q_MAX - 1);           // far into the last segment
      wait_until_drained();
      // Two entries spanning the whole range: largest product and divisor.
      write_register(CSR_TABLE_LENGTH, DATA_W'(2));
      queue_write(1, Q_MAX, Q_MIN);
      queue_query(Q_MAX - 1);
      // Unordered pair: x is below the first and above the last, last wins.
      queue_write(0, 10, 11);
      queue_write(1, -5, 77);
      queue_query(0);

      // Random phases. Each one starts only once the previous one has fully
      // drained, so the sender pauses with nothing outstanding before every
      // register write. Lengths cover zero, one, two, full, above full and
      // the 5-bit maximum; the single coefficient takes both extremes.
      phase_length = '{16, 2, 0, 31, 1, 0, 17, 16};
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();
         len = (p == 5) ? $urandom_range(3, MAX_POINTS - 1) : phase_length[p];
         write_register(CSR_TABLE_LENGTH, ($urandom() & ~32'h1F) | DATA_W'(len));
         case (p)
            1:       write_register(CSR_SINGLE_COEFF, 32'h8000_0000);
            2:       write_register(CSR_SINGLE_COEFF, 32'h7FFF_FFFF);
            default: write_register(CSR_SINGLE_COEFF, $urandom());
         endcase
         case (p % 4)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         n_eff = (len == 0) ? 1 : (len > MAX_POINTS) ? MAX_POINTS : len;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
               rewrite_table((n_eff < 2) ? 2 : n_eff);
               repeat ($urandom_range(3, 8)) queue_query(pick_query_temperature(n_eff));
            end else if (pick < 70) begin
               rewrite_entry(n_eff);
               repeat ($urandom_range(2, 6)) queue_query(pick_query_temperature(n_eff));
            end else if (pick < 85) begin
               // noise: any entry, any content, may leave the table unordered
               queue_write($urandom_range(MAX_POINTS - 1), longint'(int'($urandom())),
                           longint'(int'($urandom())));
            end else begin
               repeat ($urandom_range(1, 3)) queue_query(rand_between(Q_MIN, Q_MAX));
            end
         end
      end

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
